@@ rtl/aet_pkg.sv @@
// Shared types, token and error codes and character constants for the
// arithmetic expression tokenizer. No dependencies.
`default_nettype none

package aet_pkg;

  // Default nesting limit; the depth register is eight bits wide
  localparam int unsigned MaxDepthDefault = 255;
  localparam int unsigned DepthWidth      = 8;

  // Request codes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Token kinds
  localparam logic [3:0] K_NUMBER = 4'd0;
  localparam logic [3:0] K_ABS    = 4'd1;
  localparam logic [3:0] K_NEG    = 4'd2;
  localparam logic [3:0] K_ADD    = 4'd3;
  localparam logic [3:0] K_SUB    = 4'd4;
  localparam logic [3:0] K_MUL    = 4'd5;
  localparam logic [3:0] K_DIV    = 4'd6;
  localparam logic [3:0] K_POW    = 4'd7;
  localparam logic [3:0] K_MOD    = 4'd8;
  localparam logic [3:0] K_OPEN   = 4'd9;
  localparam logic [3:0] K_CLOSE  = 4'd10;
  localparam logic [3:0] K_ERROR  = 4'd11;

  // Error codes
  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_ILLEGAL  = 3'd1;
  localparam logic [2:0] E_UNCLOSE  = 3'd2;
  localparam logic [2:0] E_UNOPEN   = 3'd3;
  localparam logic [2:0] E_OVERFLOW = 3'd4;
  localparam logic [2:0] E_DEEP     = 3'd5;

  // Character codes
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_PCENT  = 8'h25;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // One result token
  typedef struct packed {
    logic [3:0]  kind;
    logic [30:0] value;
    logic [2:0]  error_code;
    logic        last;
  } result_t;

  // Up to two tokens produced by one request, in stream order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

`default_nettype wire

@@ rtl/aet_char_if.sv @@
// Character request channel: valid/ready handshake with op and char_code.
// No dependencies.
`default_nettype none

interface aet_char_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] char_code;

  modport source (output valid, output op, output char_code, input ready);
  modport sink   (input valid, input op, input char_code, output ready);
endinterface

`default_nettype wire

@@ rtl/aet_tok_if.sv @@
// Token result channel: valid/ready handshake with the token fields.
// No dependencies.
`default_nettype none

interface aet_tok_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [30:0] value;
  logic [2:0]  error_code;
  logic        last;

  modport source (output valid, output kind, output value, output error_code,
                  output last, input ready);
  modport sink   (input valid, input kind, input value, input error_code,
                  input last, output ready);
endinterface

`default_nettype wire

@@ rtl/aet_lexer.sv @@
// Lexer state and per-character decode: turns one request into up to two
// tokens. Depends on aet_pkg and aet_char_if.
`default_nettype none

module aet_lexer #(
  parameter int unsigned MAX_DEPTH = aet_pkg::MaxDepthDefault
) (
  input  wire logic   clk,
  input  wire logic   rst,
  aet_char_if.sink    char_in,
  input  wire logic   room,
  output aet_pkg::push_t push
);

  localparam logic [aet_pkg::DepthWidth-1:0] DepthLimit =
    (MAX_DEPTH > 255) ? 8'd255 : MAX_DEPTH[aet_pkg::DepthWidth-1:0];

  logic [30:0] acc, acc_next;
  logic        in_num, in_num_next;
  logic        after_op, after_op_next;
  logic [aet_pkg::DepthWidth-1:0] depth, depth_next;
  logic        err, err_next;

  logic             accept;
  logic             is_digit;
  logic [3:0]       digit;
  logic [30:0]      base;
  logic [34:0]      v;
  logic             flush_v;
  logic             tok_v;
  aet_pkg::result_t num_res;
  aet_pkg::result_t tok;

  assign char_in.ready = room;
  assign accept        = char_in.valid & room;

  // Digits sit at 0x30 to 0x39, so the low nibble is the digit value
  assign digit      = char_in.char_code[3:0];
  assign is_digit   = (char_in.char_code >= aet_pkg::CH_ZERO) &&
                      (char_in.char_code <= aet_pkg::CH_NINE);
  assign base       = in_num ? acc : 31'd0;
  // Multiply by ten as two shifts, then add the digit
  assign v = ({4'd0, base} << 3) + ({4'd0, base} << 1) + {31'd0, digit};

  // Decode the request against the current state
  always_comb begin
    acc_next      = acc;
    in_num_next   = in_num;
    after_op_next = after_op;
    depth_next    = depth;
    err_next      = err;
    flush_v       = 1'b0;
    tok_v         = 1'b0;
    num_res       = '0;
    num_res.kind  = aet_pkg::K_NUMBER;
    num_res.value = acc;
    tok           = '0;

    if (char_in.op == aet_pkg::OP_END) begin
      if (!err) begin
        flush_v = in_num;
        if (depth != '0) begin
          tok_v          = 1'b1;
          tok.kind       = aet_pkg::K_ERROR;
          tok.error_code = aet_pkg::E_UNOPEN;
        end
      end
      acc_next      = '0;
      in_num_next   = 1'b0;
      after_op_next = 1'b1;
      depth_next    = '0;
      err_next      = 1'b0;
    end else if (err) begin
      // drop everything until the end request
    end else if (is_digit) begin
      after_op_next = 1'b0;
      if (v[34:31] != 4'd0) begin
        acc_next       = '0;
        in_num_next    = 1'b0;
        err_next       = 1'b1;
        tok_v          = 1'b1;
        tok.kind       = aet_pkg::K_ERROR;
        tok.error_code = aet_pkg::E_OVERFLOW;
      end else begin
        acc_next    = v[30:0];
        in_num_next = 1'b1;
      end
    end else begin
      flush_v     = in_num;
      acc_next    = '0;
      in_num_next = 1'b0;
      unique case (char_in.char_code)
        aet_pkg::CH_PLUS: begin
          tok_v         = 1'b1;
          tok.kind      = after_op ? aet_pkg::K_ABS : aet_pkg::K_ADD;
          after_op_next = 1'b1;
        end
        aet_pkg::CH_MINUS: begin
          tok_v         = 1'b1;
          tok.kind      = after_op ? aet_pkg::K_NEG : aet_pkg::K_SUB;
          after_op_next = 1'b1;
        end
        aet_pkg::CH_STAR: begin
          tok_v         = 1'b1;
          tok.kind      = aet_pkg::K_MUL;
          after_op_next = 1'b1;
        end
        aet_pkg::CH_SLASH: begin
          tok_v         = 1'b1;
          tok.kind      = aet_pkg::K_DIV;
          after_op_next = 1'b1;
        end
        aet_pkg::CH_CARET: begin
          tok_v         = 1'b1;
          tok.kind      = aet_pkg::K_POW;
          after_op_next = 1'b1;
        end
        aet_pkg::CH_PCENT: begin
          tok_v         = 1'b1;
          tok.kind      = aet_pkg::K_MOD;
          after_op_next = 1'b1;
        end
        aet_pkg::CH_LPAREN: begin
          tok_v = 1'b1;
          if (depth >= DepthLimit) begin
            tok.kind       = aet_pkg::K_ERROR;
            tok.error_code = aet_pkg::E_DEEP;
            err_next       = 1'b1;
          end else begin
            tok.kind      = aet_pkg::K_OPEN;
            depth_next    = depth + 8'd1;
            after_op_next = 1'b1;
          end
        end
        aet_pkg::CH_RPAREN: begin
          tok_v = 1'b1;
          if (depth == '0) begin
            tok.kind       = aet_pkg::K_ERROR;
            tok.error_code = aet_pkg::E_UNCLOSE;
            err_next       = 1'b1;
          end else begin
            tok.kind      = aet_pkg::K_CLOSE;
            depth_next    = depth - 8'd1;
            after_op_next = 1'b0;
          end
        end
        aet_pkg::CH_SPACE: begin
          // ends a pending number only
        end
        default: begin
          tok_v          = 1'b1;
          tok.kind       = aet_pkg::K_ERROR;
          tok.value      = {23'd0, char_in.char_code};
          tok.error_code = aet_pkg::E_ILLEGAL;
          err_next       = 1'b1;
        end
      endcase
    end
  end

  // Pack the number token ahead of the character's token
  always_comb begin
    push = '0;
    if (flush_v) begin
      push.first  = num_res;
      push.second = tok;
      push.count  = tok_v ? 2'd2 : 2'd1;
    end else begin
      push.first  = tok;
      push.second = tok;
      push.count  = tok_v ? 2'd1 : 2'd0;
    end
    push.first.last  = (push.count == 2'd1);
    push.second.last = 1'b1;
    if (!accept) begin
      push.count = 2'd0;
    end
  end

  // Hold lexer state; advance on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      in_num   <= 1'b0;
      after_op <= 1'b1;
      depth    <= '0;
      err      <= 1'b0;
    end else if (accept) begin
      acc      <= acc_next;
      in_num   <= in_num_next;
      after_op <= after_op_next;
      depth    <= depth_next;
      err      <= err_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/aet_out_buf.sv @@
// Four-entry result queue: takes up to two tokens a cycle, hands out one.
// Depends on aet_pkg and aet_tok_if.
`default_nettype none

module aet_out_buf (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire aet_pkg::push_t push,
  output logic               room,
  aet_tok_if.source          tok_out
);

  aet_pkg::result_t entries [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic [2:0] count_next;
  logic       pop;
  aet_pkg::result_t head;

  // Leave space for a two-token request
  assign room = (count <= 3'd2);

  assign head               = entries[rd_ptr];
  assign tok_out.valid      = (count != 3'd0);
  assign tok_out.kind       = head.kind;
  assign tok_out.value      = head.value;
  assign tok_out.error_code = head.error_code;
  assign tok_out.last       = head.last;

  assign pop        = tok_out.valid & tok_out.ready;
  assign count_next = count + {1'b0, push.count} - {2'd0, pop};

  // Store pushed tokens
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + 2'd1] <= push.second;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/arithmetic_expression_tokenizer_core.sv @@
// Arithmetic expression tokenizer: one character request per cycle in, tokens out.
// Each token is registered in the result queue before it is offered on tok_out.
// Throughput: one request per cycle while the four-entry result queue has space
// for two tokens; requests that give two tokens drain at one token per cycle.
// Reset (rst, synchronous): clears lexer state and empties the result queue.
// Depends on aet_pkg, aet_char_if, aet_tok_if, aet_lexer, aet_out_buf.
`default_nettype none

module arithmetic_expression_tokenizer_core #(
  parameter int unsigned MAX_DEPTH = aet_pkg::MaxDepthDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  aet_char_if.sink  tok_in,
  aet_tok_if.source tok_out
);

  aet_pkg::push_t push;
  logic           room;

  // Decode requests and keep lexer state
  aet_lexer #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_lexer (
    .clk     (clk),
    .rst     (rst),
    .char_in (tok_in),
    .room    (room),
    .push    (push)
  );

  // Queue tokens towards the output
  aet_out_buf u_out_buf (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .room    (room),
    .tok_out (tok_out)
  );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for arithmetic_expression_tokenizer_core: queued character
// requests, a token predictor and a field-by-field token check under random idling.
// Depends on aet_pkg, aet_char_if, aet_tok_if and the tokenizer RTL.

module testbench;

  typedef struct packed {
    logic       op;
    logic [7:0] ch;
  } char_req_t;

  localparam int unsigned DepthLimit =
    (aet_pkg::MaxDepthDefault > 255) ? 255 : aet_pkg::MaxDepthDefault;
  localparam logic [7:0] BinaryOps [6] = '{aet_pkg::CH_PLUS, aet_pkg::CH_MINUS,
                                           aet_pkg::CH_STAR, aet_pkg::CH_SLASH,
                                           aet_pkg::CH_CARET, aet_pkg::CH_PCENT};

  logic clk = 1'b0;
  logic rst = 1'b1;

  aet_char_if tok_in ();
  aet_tok_if  tok_out ();

  arithmetic_expression_tokenizer_core dut (
    .clk     (clk),
    .rst     (rst),
    .tok_in  (tok_in.sink),
    .tok_out (tok_out.source)
  );

  // Pending character requests and tokens still owed by the block
  char_req_t        char_requests[$];
  aet_pkg::result_t expected_tokens[$];
  aet_pkg::result_t step_out[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        recv_blocked = 1'b0;

  int unsigned requests_queued = 0;
  int unsigned requests_accepted = 0;
  int unsigned tokens_checked = 0;
  int unsigned error_tokens = 0;
  int unsigned failures = 0;

  // Lexer state of the predictor
  logic [30:0] lex_acc;
  logic        lex_in_number;
  logic        lex_after_op;
  logic [7:0]  lex_depth;
  logic        lex_error;
  logic [7:0]  deepest_nesting = 8'd0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  task lexer_reset();
    lex_acc       = 31'd0;
    lex_in_number = 1'b0;
    lex_after_op  = 1'b1;
    lex_depth     = 8'd0;
    lex_error     = 1'b0;
  endtask

  task add_token(input logic [3:0] kind, input logic [30:0] value, input logic [2:0] err);
    aet_pkg::result_t tok;
    tok.kind       = kind;
    tok.value      = value;
    tok.error_code = err;
    tok.last       = 1'b0;
    step_out.push_back(tok);
  endtask

  task raise_error(input logic [2:0] err, input logic [30:0] value);
    add_token(aet_pkg::K_ERROR, value, err);
    lex_error = 1'b1;
  endtask

  task operator_token(input logic [3:0] kind);
    add_token(kind, 31'd0, aet_pkg::E_NONE);
    lex_after_op = 1'b1;
  endtask

  task flush_number();
    if (lex_in_number) begin
      add_token(aet_pkg::K_NUMBER, lex_acc, aet_pkg::E_NONE);
      lex_in_number = 1'b0;
      lex_acc       = 31'd0;
    end
  endtask

  // Work out the tokens one accepted request gives and queue them
  task tokenize_char(input char_req_t req);
    logic [63:0]      wide;
    aet_pkg::result_t tok;
    step_out.delete();
    if (req.op == aet_pkg::OP_END) begin
      if (!lex_error) begin
        flush_number();
        if (lex_depth != 8'd0) raise_error(aet_pkg::E_UNOPEN, 31'd0);
      end
      lexer_reset();
    end else if (lex_error) begin
      // drop everything until the end request
    end else if (req.ch >= aet_pkg::CH_ZERO && req.ch <= aet_pkg::CH_NINE) begin
      wide = lex_in_number ? 64'(lex_acc) * 64'd10 : 64'd0;
      wide = wide + 64'(req.ch - aet_pkg::CH_ZERO);
      lex_after_op = 1'b0;
      if (wide > 64'd2147483647) begin
        lex_in_number = 1'b0;
        lex_acc       = 31'd0;
        raise_error(aet_pkg::E_OVERFLOW, 31'd0);
      end else begin
        lex_acc       = wide[30:0];
        lex_in_number = 1'b1;
      end
    end else begin
      flush_number();
      case (req.ch)
        aet_pkg::CH_PLUS:
          operator_token(lex_after_op ? aet_pkg::K_ABS : aet_pkg::K_ADD);
        aet_pkg::CH_MINUS:
          operator_token(lex_after_op ? aet_pkg::K_NEG : aet_pkg::K_SUB);
        aet_pkg::CH_STAR:  operator_token(aet_pkg::K_MUL);
        aet_pkg::CH_SLASH: operator_token(aet_pkg::K_DIV);
        aet_pkg::CH_CARET: operator_token(aet_pkg::K_POW);
        aet_pkg::CH_PCENT: operator_token(aet_pkg::K_MOD);
        aet_pkg::CH_LPAREN: begin
          if (lex_depth >= DepthLimit) begin
            raise_error(aet_pkg::E_DEEP, 31'd0);
          end else begin
            lex_depth = lex_depth + 8'd1;
            if (lex_depth > deepest_nesting) deepest_nesting = lex_depth;
            operator_token(aet_pkg::K_OPEN);
          end
        end
        aet_pkg::CH_RPAREN: begin
          if (lex_depth == 8'd0) begin
            raise_error(aet_pkg::E_UNCLOSE, 31'd0);
          end else begin
            lex_depth = lex_depth - 8'd1;
            add_token(aet_pkg::K_CLOSE, 31'd0, aet_pkg::E_NONE);
            lex_after_op = 1'b0;
          end
        end
        aet_pkg::CH_SPACE: ;
        default: raise_error(aet_pkg::E_ILLEGAL, 31'(req.ch));
      endcase
    end
    foreach (step_out[i]) begin
      tok      = step_out[i];
      tok.last = (i == step_out.size() - 1);
      expected_tokens.push_back(tok);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : char_driver
    char_req_t req;
    if (rst) begin
      tok_in.valid     <= 1'b0;
      tok_in.op        <= aet_pkg::OP_CHAR;
      tok_in.char_code <= 8'd0;
    end else if (!tok_in.valid || tok_in.ready) begin
      if (char_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req = char_requests.pop_front();
        tok_in.valid     <= 1'b1;
        tok_in.op        <= req.op;
        tok_in.char_code <= req.ch;
      end else begin
        tok_in.valid <= 1'b0;
      end
    end
  end

  // Token sink: random stalls, or hold off completely while blocked
  always @(posedge clk) begin
    if (rst) begin
      tok_out.ready <= 1'b0;
    end else begin
      tok_out.ready <= !recv_blocked && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on accepted requests, then compare accepted tokens
  // ---------------------------------------------------------------------------
  function void check_field(input string name, input logic [30:0] want,
                            input logic [30:0] got);
    if (want !== got) begin
      $display("%0t: token %0d %s mismatch: expected %0d, actual %0d",
               $time, tokens_checked, name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin : token_monitor
    aet_pkg::result_t want;
    if (!rst) begin
      if (tok_in.valid && tok_in.ready) begin
        tokenize_char('{op: tok_in.op, ch: tok_in.char_code});
        requests_accepted++;
      end
      if (tok_out.valid && tok_out.ready) begin
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected token: expected none, actual kind %0d value %0d err %0d",
                   $time, tok_out.kind, tok_out.value, tok_out.error_code);
          failures++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("kind", 31'(want.kind), 31'(tok_out.kind));
          check_field("value", want.value, tok_out.value);
          check_field("error_code", 31'(want.error_code), 31'(tok_out.error_code));
          check_field("last", 31'(want.last), 31'(tok_out.last));
          if (tok_out.kind == aet_pkg::K_ERROR) error_tokens++;
          tokens_checked++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task send_char(input logic [7:0] ch);
    char_requests.push_back('{op: aet_pkg::OP_CHAR, ch: ch});
    requests_queued++;
  endtask

  task send_end();
    char_requests.push_back('{op: aet_pkg::OP_END, ch: 8'($urandom_range(255))});
    requests_queued++;
  endtask

  task send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_number();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(99);
    if (pick < 60) len = $urandom_range(1, 3);
    else if (pick < 90) len = $urandom_range(4, 10);
    else len = $urandom_range(11, 12);
    for (int i = 0; i < len; i++) send_char(aet_pkg::CH_ZERO + 8'($urandom_range(9)));
  endtask

  task automatic send_operand(input int level);
    if ($urandom_range(99) < 20)
      send_char($urandom_range(1) ? aet_pkg::CH_MINUS : aet_pkg::CH_PLUS);
    if (level < 3 && $urandom_range(99) < 25) begin
      send_char(aet_pkg::CH_LPAREN);
      send_expression(level + 1);
      send_char(aet_pkg::CH_RPAREN);
    end else begin
      send_number();
    end
  endtask

  task automatic send_expression(input int level);
    int unsigned terms;
    terms = $urandom_range(1, 4);
    for (int t = 0; t < terms; t++) begin
      if (t != 0) begin
        if ($urandom_range(9) == 0) send_char(aet_pkg::CH_SPACE);
        send_char(BinaryOps[$urandom_range(5)]);
        if ($urandom_range(9) == 0) send_char(aet_pkg::CH_SPACE);
      end
      send_operand(level);
    end
  endtask

  // Well-formed content with one fault: open left, stray close, bad byte, overflow
  task automatic send_broken();
    case ($urandom_range(3))
      0: begin
        send_char(aet_pkg::CH_LPAREN);
        send_expression(1);
      end
      1: begin
        send_expression(0);
        send_char(aet_pkg::CH_RPAREN);
        send_expression(0);
      end
      2: begin
        send_expression(0);
        send_char(8'($urandom_range(255)));
        send_expression(0);
      end
      default: begin
        send_text("4294967296");
        send_expression(0);
      end
    endcase
    send_end();
  endtask

  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) send_char(8'($urandom_range(255)));
    send_end();
  endtask

  // Hold the sender back until every owed token has arrived
  task wait_drained();
    while (char_requests.size() != 0 || tok_in.valid || expected_tokens.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    stop_at = requests_queued + count;
    while (requests_queued < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_expression(0);
        send_end();
      end else if (pick < 88) begin
        send_broken();
      end else begin
        send_noise();
      end
    end
    wait_drained();
  endtask

  initial begin
    tok_in.valid     = 1'b0;
    tok_in.op        = aet_pkg::OP_CHAR;
    tok_in.char_code = 8'd0;
    tok_out.ready    = 1'b0;
    lexer_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: every operator, unary and binary forms, space, paren errors,
    // two tokens at the end, latched illegal byte, lowest byte
    send_text("-(+9 *3/0^5%6-7)+1");
    send_end();
    send_char(aet_pkg::CH_RPAREN);
    send_end();
    send_text("(5");
    send_end();
    send_char(8'hFF);
    send_char(aet_pkg::CH_NINE);
    send_end();
    send_char(8'h00);
    send_end();
    wait_drained();

    // Largest number, overflow on the last digit, and the nesting limit
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    send_text("2147483647");
    send_end();
    send_text("2147483648");
    send_end();
    send_text("99999999999+1");
    send_end();
    repeat (DepthLimit) send_char(aet_pkg::CH_LPAREN);
    send_char(aet_pkg::CH_ZERO + 8'd7);
    send_char(aet_pkg::CH_LPAREN);
    send_end();
    wait_drained();

    // Random phases
    run_phase(0, 0, 50);
    run_phase(82, 0, 50);
    run_phase(0, 82, 50);
    run_phase(23, 23, 60);

    // Back-pressure: sink holds off while the sender keeps offering
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    recv_blocked   = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk);
        recv_blocked = 1'b0;
      end
    join_none
    run_phase(0, 0, 60);

    wait_drained();
    repeat (10) @(negedge clk);
    $display("Run covered %0d requests and %0d tokens, %0d of them error tokens,",
             requests_accepted, tokens_checked, error_tokens);
    $display("with nesting up to depth %0d and %0d mismatches.", deepest_nesting, failures);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule
